@@ hdl/pee_pkg.sv @@
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types, character codes and status codes of the postfix evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  // Operand word
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  // Expression characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDX,
    S_RDY,
    S_OPN,
    S_EXEC,
    S_FIN,
    S_EMIT
  } state_e;

  // Request from the sequencer to the serial unit
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // Keep only the first error of an expression
  function automatic logic [1:0] flag_err(input logic [1:0] cur, input logic [1:0] code);
    flag_err = (cur == ST_OK) ? code : cur;
  endfunction

  function automatic alu_op_e decode_op(input logic [7:0] sym);
    alu_op_e op;
    case (sym)
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  op = OP_ADD;
    endcase
    decode_op = op;
  endfunction

endpackage

@@ hdl/pee_if.sv @@
// ----------------------------------------------------------------------------
// pee_in_if / pee_out_if
// Valid/ready channels carrying expression characters in and results out.
// ----------------------------------------------------------------------------
interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

interface pee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ hdl/pee_stack.sv @@
// ----------------------------------------------------------------------------
// pee_stack
// Operand stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pee_stack
  import pee_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned AW          = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/pee_alu.sv @@
// ----------------------------------------------------------------------------
// pee_alu
// Bit-serial arithmetic unit: add/sub one bit per cycle, shift-add multiply,
// restoring divide one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pee_alu
  import pee_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alu_req_t          req_i,
  input  logic [DATA_W-1:0] a_i,      // second popped (left operand)
  input  logic [DATA_W-1:0] b_i,      // first popped (right operand)
  output logic              done_o,
  output logic [DATA_W-1:0] result_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  alu_op_e           op_q;
  logic [DATA_W-1:0] a_q, a_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              carry_q, carry_d;
  logic              neg_q;

  logic              bb, sb;
  logic [DATA_W:0]   rem_sh, diff;
  logic              is_div;

  assign is_div = (req_i.op == OP_DIV);

  // One serial step
  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    carry_d = carry_q;
    bb      = b_q[0] ^ (op_q == OP_SUB);
    sb      = a_q[0] ^ bb ^ carry_q;
    rem_sh  = {acc_q, a_q[DATA_W-1]};
    diff    = rem_sh - {1'b0, b_q};
    case (op_q)
      OP_ADD, OP_SUB: begin
        acc_d   = {sb, acc_q[DATA_W-1:1]};
        carry_d = (a_q[0] & bb) | (a_q[0] & carry_q) | (bb & carry_q);
        a_d     = {1'b0, a_q[DATA_W-1:1]};
        b_d     = {1'b0, b_q[DATA_W-1:1]};
      end
      OP_MUL: begin
        acc_d = acc_q + (b_q[0] ? a_q : '0);
        a_d   = {a_q[DATA_W-2:0], 1'b0};
        b_d   = {1'b0, b_q[DATA_W-1:1]};
      end
      OP_DIV: begin
        if (!diff[DATA_W]) begin
          acc_d = diff[DATA_W-1:0];
          a_d   = {a_q[DATA_W-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[DATA_W-1:0];
          a_d   = {a_q[DATA_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Step counter and handshake
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + STEP_W'(1);
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Operand shift registers; divide works on magnitudes
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q    <= req_i.op;
      a_q     <= (is_div && a_i[DATA_W-1]) ? (DATA_W'(0) - a_i) : a_i;
      b_q     <= (is_div && b_i[DATA_W-1]) ? (DATA_W'(0) - b_i) : b_i;
      acc_q   <= '0;
      carry_q <= (req_i.op == OP_SUB);
      neg_q   <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
    end else if (busy_q) begin
      a_q     <= a_d;
      b_q     <= b_d;
      acc_q   <= acc_d;
      carry_q <= carry_d;
    end
  end

  // Quotient sign fix on the way out
  assign done_o   = done_q;
  assign result_o = (op_q == OP_DIV) ? (neg_q ? (DATA_W'(0) - a_q) : a_q) : acc_q;

endmodule

@@ hdl/postfix_expression_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Postfix expression evaluator over a 32-bit signed operand stack.
//
//   Channel  Dir  Fields                         Accepted when
//   expr_i   in   symbol[7:0], end_of_expr       valid & ready
//   res_o    out  value[31:0] signed, status[1:0] valid & ready
//
// A digit is accepted and retired; an operator is accepted, makes two stack reads,
// starts the bit-serial unit (32 steps and done) and retires. Divide by zero and an
// operator on a short stack end before the unit is started. The final character
// also loads the result register.
// Reset clears stack count, error and handshake state; stack memory is not
// cleared. A full result register stalls only the final character of an item run.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top
  import pee_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pee_in_if.sink      expr_i,
  pee_out_if.source   res_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [1:0]        err_q, err_d;
  logic [7:0]        sym_q, sym_d;
  logic              last_q, last_d;
  alu_op_e           op_q, op_d;
  logic [DATA_W-1:0] x_q, x_d;
  logic              top_ok_q, top_ok_d;
  logic              res_valid_q;
  logic [DATA_W-1:0] res_value_q;
  logic [1:0]        res_status_q;
  logic              res_load;

  logic              in_ready;
  logic              is_op;
  logic [CW-1:0]     cnt_m1, cnt_m2;

  logic              stk_we, stk_re;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [DATA_W-1:0] stk_wdata, stk_rdata;

  alu_req_t          alu_req;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  assign is_op = (expr_i.symbol == CH_PLUS) || (expr_i.symbol == CH_MINUS) ||
                 (expr_i.symbol == CH_STAR) || (expr_i.symbol == CH_SLASH);
  assign cnt_m1 = cnt_q - CW'(1);
  assign cnt_m2 = cnt_q - CW'(2);

  pee_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Left operand arrives from the stack read port, right one from x_q
  pee_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (stk_rdata),
    .b_i      (x_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  // Sequencer: next state and stack/unit controls
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    sym_d     = sym_q;
    last_d    = last_q;
    op_d      = op_q;
    x_d       = x_q;
    top_ok_d  = top_ok_q;
    in_ready  = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_re    = 1'b0;
    stk_raddr = '0;
    alu_req   = '0;
    res_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (expr_i.valid) begin
          sym_d  = expr_i.symbol;
          last_d = expr_i.end_of_expr;
          op_d   = decode_op(expr_i.symbol);
          if (is_op) begin
            if (cnt_q < CW'(2)) begin
              err_d   = flag_err(err_q, ST_UNDERFLOW);
              state_d = S_FIN;
            end else begin
              state_d = S_RDX;
            end
          end else begin
            if (cnt_q == CW'(STACK_DEPTH)) begin
              err_d = flag_err(err_q, ST_OVERFLOW);
            end else begin
              stk_we    = 1'b1;
              stk_waddr = cnt_q[AW-1:0];
              stk_wdata = {{(DATA_W-8){1'b0}}, expr_i.symbol} - {{(DATA_W-8){1'b0}}, CH_ZERO};
              cnt_d     = cnt_q + CW'(1);
            end
            state_d = S_FIN;
          end
        end
      end
      S_RDX: begin
        stk_re    = 1'b1;
        stk_raddr = cnt_m1[AW-1:0];
        state_d   = S_RDY;
      end
      S_RDY: begin
        stk_re    = 1'b1;
        stk_raddr = cnt_m2[AW-1:0];
        x_d       = stk_rdata;
        state_d   = S_OPN;
      end
      S_OPN: begin
        if ((op_q == OP_DIV) && (x_q == '0)) begin
          err_d   = flag_err(err_q, ST_DIVZERO);
          state_d = S_FIN;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = op_q;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_done) begin
          stk_we    = 1'b1;
          stk_waddr = cnt_m2[AW-1:0];
          stk_wdata = alu_result;
          cnt_d     = cnt_m1;
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (cnt_q == '0) begin
          err_d    = flag_err(err_q, ST_UNDERFLOW);
          top_ok_d = 1'b0;
          state_d  = S_EMIT;
        end else begin
          stk_re    = 1'b1;
          stk_raddr = cnt_m1[AW-1:0];
          top_ok_d  = 1'b1;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!res_valid_q || res_o.ready) begin
          res_load = 1'b1;
          cnt_d    = '0;
          err_d    = ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_q    <= sym_d;
    last_q   <= last_d;
    op_q     <= op_d;
    x_q      <= x_d;
    top_ok_q <= top_ok_d;
    if (res_load) begin
      res_value_q  <= top_ok_q ? stk_rdata : '0;
      res_status_q <= err_q;
    end
  end

  assign expr_i.ready = in_ready;
  assign res_o.valid  = res_valid_q;
  assign res_o.value  = $signed(res_value_q);
  assign res_o.status = res_status_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_done_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == S_EXEC))
    else $error("serial unit finished outside execute");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |=> (res_valid_q && $stable(res_value_q)))
    else $error("pending result overwritten");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((err_q != ST_OK) && !res_load) |=> $stable(err_q))
    else $error("error code changed before result");

  a_sym_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OPN) |-> (op_q == decode_op(sym_q)))
    else $error("operator decode mismatch");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the postfix expression evaluator. A short table of
// hand-picked characters comes first. Random expressions follow: mostly
// well-formed, some deep enough to overflow the stack, some noise. Idling
// changes from phase to phase. Each result is scored against a hand-entered value
// or against an in-bench stack evaluator.
// ----------------------------------------------------------------------------
module tb;
  import pee_pkg::*;

  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       typed;   // result below is hand-entered
    res_t       res;
  } row_t;

  localparam logic [7:0] OPS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  // Directed characters; untyped rows are scored against the evaluator
  localparam int unsigned N_ROWS = 27;
  localparam row_t DIRECTED [N_ROWS] = '{
    // largest byte pushes 255 - 48
    '{8'hFF,    1'b1, 1'b1, '{32'd207, ST_OK}},
    // operator on an empty stack, empty at the end
    '{CH_PLUS,  1'b1, 1'b1, '{32'd0, ST_UNDERFLOW}},
    // 7 3 - 2 + : operand order of subtract
    '{"7",      1'b0, 1'b0, '{32'd0, ST_OK}},
    '{"3",      1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_MINUS, 1'b0, 1'b0, '{32'd0, ST_OK}},
    '{"2",      1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_PLUS,  1'b1, 1'b1, '{32'd6, ST_OK}},
    // zero byte pushes -48; -48 / 5 truncates toward zero
    '{8'h00,    1'b0, 1'b0, '{32'd0, ST_OK}},
    '{"5",      1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_SLASH, 1'b1, 1'b1, '{32'hFFFF_FFF7, ST_OK}},
    // underflow held over a later divide by zero, operands kept
    '{"9",      1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_PLUS,  1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_ZERO,  1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_SLASH, 1'b1, 1'b1, '{32'd0, ST_UNDERFLOW}},
    // 128^4 * 8 wraps to the most negative value, then divide by -1
    '{8'hB0,    1'b0, 1'b0, '{32'd0, ST_OK}},
    '{8'hB0,    1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_STAR,  1'b0, 1'b0, '{32'd0, ST_OK}},
    '{8'hB0,    1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_STAR,  1'b0, 1'b0, '{32'd0, ST_OK}},
    '{8'hB0,    1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_STAR,  1'b0, 1'b0, '{32'd0, ST_OK}},
    '{"8",      1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_STAR,  1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_ZERO,  1'b0, 1'b0, '{32'd0, ST_OK}},
    '{"1",      1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_MINUS, 1'b0, 1'b0, '{32'd0, ST_OK}},
    '{CH_SLASH, 1'b1, 1'b1, '{32'h8000_0000, ST_OK}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Evaluator state
  logic [31:0] opnd_stack [STACK_DEPTH];
  int unsigned opnd_cnt;
  logic [1:0]  held_err;
  res_t        pending_results [$];

  pee_in_if  expr_if ();
  pee_out_if res_if ();

  postfix_expression_evaluator_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .expr_i(expr_if.sink),
    .res_o (res_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic bit is_operator(input logic [7:0] s);
    return (s == CH_PLUS) || (s == CH_MINUS) || (s == CH_STAR) || (s == CH_SLASH);
  endfunction

  // First error of an expression sticks
  function automatic void note_error(input logic [1:0] code);
    if (held_err == ST_OK) held_err = code;
  endfunction

  // Apply one character to the stack; returns 1 with the result on the last one
  function automatic bit eval_symbol(input logic [7:0] sym, input logic last,
                                     output res_t res);
    logic [31:0] x, y, r, q, mx, my;
    res = '0;
    if (!is_operator(sym)) begin
      if (opnd_cnt >= STACK_DEPTH) begin
        note_error(ST_OVERFLOW);
      end else begin
        opnd_stack[opnd_cnt] = {24'd0, sym} - 32'd48;
        opnd_cnt++;
      end
    end else if (opnd_cnt < 2) begin
      note_error(ST_UNDERFLOW);
    end else begin
      x = opnd_stack[opnd_cnt-1];   // top
      y = opnd_stack[opnd_cnt-2];
      if (sym == CH_SLASH && x == '0) begin
        note_error(ST_DIVZERO);
      end else begin
        case (sym)
          CH_PLUS:  r = y + x;
          CH_MINUS: r = y - x;
          CH_STAR:  r = y * x;
          default: begin
            // magnitudes, then sign; most negative / -1 wraps back to itself
            mx = x[31] ? -x : x;
            my = y[31] ? -y : y;
            q  = my / mx;
            r  = (x[31] ^ y[31]) ? -q : q;
          end
        endcase
        opnd_cnt--;
        opnd_stack[opnd_cnt-1] = r;
      end
    end
    if (!last) return 1'b0;
    if (opnd_cnt == 0) begin
      res.value = '0;
      note_error(ST_UNDERFLOW);
    end else begin
      res.value = opnd_stack[opnd_cnt-1];
    end
    res.status = held_err;
    opnd_cnt   = 0;
    held_err   = ST_OK;
    return 1'b1;
  endfunction

  // Result side: score accepted items, stall at random
  task automatic check_result(input logic [31:0] value, input logic [1:0] status);
    res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                $signed(value), status));
      return;
    end
    want = pending_results.pop_front();
    if (value !== want.value)
      report_mismatch($sformatf("value %0d, expected %0d",
                                $signed(value), $signed(want.value)));
    if (status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
  endtask

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      check_result(res_if.value, res_if.status);
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Expression side: hold valid until the item is taken
  task automatic send_item(input logic [7:0] sym, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      expr_if.valid <= 1'b0;
      @(posedge clk);
    end
    expr_if.valid       <= 1'b1;
    expr_if.symbol      <= sym;
    expr_if.end_of_expr <= last;
    do @(posedge clk); while (!expr_if.ready);
    items_sent++;
  endtask

  task automatic issue(input logic [7:0] sym, input logic last);
    res_t r;
    send_item(sym, last);
    if (eval_symbol(sym, last, r)) pending_results.push_back(r);
  endtask

  // Hold off until every expected result is in
  task automatic wait_results_drained();
    expr_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Mostly decimal digits, sometimes any non-operator byte
  function automatic logic [7:0] rand_operand();
    logic [7:0] s;
    if ($urandom_range(9) < 7) return CH_ZERO + 8'($urandom_range(9));
    do s = 8'($urandom_range(255)); while (is_operator(s));
    return s;
  endfunction

  // Valid postfix expression reducing to one value
  task automatic send_wellformed();
    int unsigned n_opnd, pushed, depth;
    n_opnd = $urandom_range(1, 7);
    pushed = 0;
    depth  = 0;
    while (pushed < n_opnd || depth > 1) begin
      if (pushed < n_opnd && (depth < 2 || $urandom_range(1) == 1)) begin
        pushed++;
        depth++;
        issue(rand_operand(), pushed == n_opnd && depth == 1);
      end else begin
        depth--;
        issue(OPS[$urandom_range(3)], pushed == n_opnd && depth == 1);
      end
    end
  endtask

  // Long run of pushes around the stack size, then a few operators
  task automatic send_deep(input int unsigned n_opnd);
    int unsigned n_oper;
    n_oper = $urandom_range(3);
    for (int unsigned i = 1; i <= n_opnd; i++)
      issue(rand_operand(), n_oper == 0 && i == n_opnd);
    for (int unsigned i = 1; i <= n_oper; i++)
      issue(OPS[$urandom_range(3)], i == n_oper);
  endtask

  // Arbitrary bytes and operators, stray end flags
  task automatic send_noise();
    int unsigned len;
    len = $urandom_range(1, 8);
    for (int unsigned i = 1; i <= len; i++)
      issue($urandom_range(1) ? OPS[$urandom_range(3)] : 8'($urandom_range(255)),
            i == len || $urandom_range(9) == 0);
  endtask

  initial begin
    res_t        r;
    int unsigned pick;
    expr_if.valid       = 1'b0;
    expr_if.symbol      = '0;
    expr_if.end_of_expr = 1'b0;
    res_if.ready        = 1'b0;
    rst_n               = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    opnd_cnt            = 0;
    held_err            = ST_OK;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].sym, DIRECTED[i].last);
      if (eval_symbol(DIRECTED[i].sym, DIRECTED[i].last, r))
        pending_results.push_back(DIRECTED[i].typed ? DIRECTED[i].res : r);
    end
    wait_results_drained();

    // Random expressions over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
      // make sure overflow is hit at least once
      if (ph == 0) send_deep(STACK_DEPTH + 2);
      while (items_sent < N_ROWS + RANDOM_ITEMS * (ph + 1) / 4) begin
        pick = $urandom_range(19);
        if (pick < 14) send_wellformed();
        else if (pick < 15) send_deep($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6));
        else send_noise();
      end
      wait_results_drained();
    end

    // Catch anything stray after the last result
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ postfix_expression_evaluator_top.f @@
hdl/pee_pkg.sv
hdl/pee_if.sv
hdl/pee_stack.sv
hdl/pee_alu.sv
hdl/postfix_expression_evaluator_top.sv
verif/tb.sv
